// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the timer queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check at every clock edge, reset phases included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Check only while the block is out of reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/sdtq_pkg.sv =====
// Types, codes and helpers shared by the sorted delay timer queue.
`timescale 1ns / 1ps

package sdtq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned GROUP_W         = 32;
  localparam int unsigned ID_W            = 32;
  localparam int unsigned PRIO_W          = 8;
  localparam int unsigned HANDLE_W        = 32;
  localparam logic [TIME_W-1:0] HALF_RANGE = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_COLLECT = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_PUSHED   = 3'd0,
    KIND_REJECTED = 3'd1,
    KIND_EXPIRED  = 3'd2,
    KIND_NONE     = 3'd3,
    KIND_TIMEOUT  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_COLLECT,
    ST_QUERY
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0]   wake_time;
    logic [GROUP_W-1:0]  group;
    logic [ID_W-1:0]     ident;
    logic [PRIO_W-1:0]   priority_v;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic              push_en;
    logic              pop_en;
    entry_t            new_entry;
    logic [TIME_W-1:0] now_ms;
  } cell_ctrl_t;

  // True when time a lies strictly later than time b on the wrapping clock.
  function automatic logic later_than(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = a - b;
    return (diff != '0) && (diff < HALF_RANGE);
  endfunction

endpackage

// ===== rtl/sdtq_cell.sv =====
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps

module sdtq_cell (
  input  logic                 clk_i,
  input  sdtq_pkg::cell_ctrl_t ctrl_i,
  input  logic                 occupied_i,
  input  logic                 left_ins_i,
  input  sdtq_pkg::entry_t     left_entry_i,
  input  sdtq_pkg::entry_t     right_entry_i,
  output sdtq_pkg::entry_t     entry_o,
  output logic                 ins_o,
  output logic                 expired_o
);

  sdtq_pkg::entry_t entry_q;
  sdtq_pkg::entry_t entry_d;

  // This slot moves on a push when a slot ahead of it moves, when it is free
  // or when it holds a later time.
  assign ins_o = left_ins_i || !occupied_i ||
                 sdtq_pkg::later_than(entry_q.wake_time, ctrl_i.new_entry.wake_time);

  assign expired_o = occupied_i && sdtq_pkg::later_than(ctrl_i.now_ms, entry_q.wake_time);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.pop_en) begin
      entry_d = right_entry_i;
    end else if (ctrl_i.push_en && ins_o) begin
      entry_d = left_ins_i ? left_entry_i : ctrl_i.new_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/sorted_delay_timer_queue_core.sv =====
// Top level of the sorted delay timer queue: controller and chain of slot cells.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Sorted delay timer queue. Holds up to QUEUE_DEPTH messages ordered by a
// wrapping 32-bit activation time (now_ms_i + delay_i); equal times leave in
// arrival order. A command is taken at a clock edge where start is high and
// busy is low. Results come out one per cycle on the result ports, each marked
// by strobe_o for exactly one cycle; the receiver cannot stall them, so it must
// take every strobed result as it appears. Push and query give one result,
// registered after the state register; busy is high until the state returns
// to idle, and no new command is taken while busy. A collect pops one expired
// entry per cycle from the head of the chain, one result per pop (a single
// none result when nothing has expired), the final one flagged by last_o. The
// single-step shift of the cell chain sets that pace. The max-delay register
// is written over its own valid/ready channel, which is always ready; write it
// only while the queue is idle. There is no clearing pass after reset.
module sorted_delay_timer_queue_core #(
  parameter int unsigned QUEUE_DEPTH = sdtq_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command_i,
  input  logic [sdtq_pkg::TIME_W-1:0]   now_ms_i,
  input  logic [sdtq_pkg::TIME_W-1:0]   delay_i,
  input  logic [sdtq_pkg::GROUP_W-1:0]  msg_grp_i,
  input  logic [sdtq_pkg::ID_W-1:0]     msg_id_i,
  input  logic [sdtq_pkg::PRIO_W-1:0]   msg_priority_i,
  input  logic [sdtq_pkg::HANDLE_W-1:0] payload_handle_i,
  // result channel
  output logic                          strobe_o,
  output logic [2:0]                    kind_o,
  output logic [sdtq_pkg::GROUP_W-1:0]  out_group_o,
  output logic [sdtq_pkg::ID_W-1:0]     out_id_o,
  output logic [sdtq_pkg::PRIO_W-1:0]   out_priority_o,
  output logic [sdtq_pkg::HANDLE_W-1:0] out_handle_o,
  output logic [sdtq_pkg::TIME_W-1:0]   out_wake_time_o,
  output logic [sdtq_pkg::TIME_W-1:0]   next_timeout_o,
  output logic [CNT_W-1:0]              pending_count_o,
  output logic                          last_o,
  // max-delay register write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sdtq_pkg::TIME_W-1:0]   cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  sdtq_pkg::state_e            state_q, state_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [sdtq_pkg::TIME_W-1:0] max_delay_q;
  logic                        strobe_q;

  // Command latched at the transfer.
  logic [sdtq_pkg::TIME_W-1:0] now_q;
  sdtq_pkg::entry_t            new_entry_q;

  // Registered result.
  sdtq_pkg::kind_e             kind_q;
  sdtq_pkg::entry_t            out_entry_q;
  logic [sdtq_pkg::TIME_W-1:0] timeout_q;
  logic [CNT_W-1:0]            pend_q;
  logic                        last_q;

  // Combinational result and chain control.
  logic                        push_en, pop_en;
  logic                        res_valid;
  sdtq_pkg::kind_e             res_kind;
  sdtq_pkg::entry_t            res_entry;
  logic [sdtq_pkg::TIME_W-1:0] res_timeout;
  logic                        res_last;

  logic                        accept;
  logic                        full;
  sdtq_pkg::cell_ctrl_t        cell_ctrl;

  // Cell chain wiring.
  sdtq_pkg::entry_t            cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]      cell_ins;
  logic [QUEUE_DEPTH-1:0]      cell_expired;
  logic [QUEUE_DEPTH-1:0]      cell_occ;

  assign busy        = (state_q != sdtq_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign full        = (count_q == CNT_W'(QUEUE_DEPTH));
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Chain of slot cells; slot 0 is the head (earliest activation time).
  // ---------------------------------------------------------------------------
  assign cell_ctrl.push_en   = push_en;
  assign cell_ctrl.pop_en    = pop_en;
  assign cell_ctrl.new_entry = new_entry_q;
  assign cell_ctrl.now_ms    = now_q;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    sdtq_pkg::entry_t left_entry;
    sdtq_pkg::entry_t right_entry;
    logic             left_ins;

    assign cell_occ[g] = (count_q > CNT_W'(g));

    if (g == 0) begin : g_head
      // The head has no left neighbor: a push that lands here takes the new entry.
      assign left_entry = new_entry_q;
      assign left_ins   = 1'b0;
    end else begin : g_body
      assign left_entry = cell_entry[g-1];
      assign left_ins   = cell_ins[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      // Nothing shifts in from beyond the tail; the slot simply becomes free.
      assign right_entry = '0;
    end else begin : g_mid
      assign right_entry = cell_entry[g+1];
    end

    sdtq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl),
      .occupied_i    (cell_occ[g]),
      .left_ins_i    (left_ins),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (cell_entry[g]),
      .ins_o         (cell_ins[g]),
      .expired_o     (cell_expired[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      sdtq_pkg::ST_IDLE: begin
        if (accept) begin
          case (sdtq_pkg::cmd_e'(command_i))
            sdtq_pkg::CMD_PUSH:    state_d = sdtq_pkg::ST_PUSH;
            sdtq_pkg::CMD_COLLECT: state_d = sdtq_pkg::ST_COLLECT;
            sdtq_pkg::CMD_QUERY:   state_d = sdtq_pkg::ST_QUERY;
            default:               state_d = sdtq_pkg::ST_IDLE; // unused code: drop it
          endcase
        end
      end
      sdtq_pkg::ST_COLLECT: begin
        // Stay while the entry behind the head has expired as well.
        if (!cell_expired[0] || !cell_expired[1]) begin
          state_d = sdtq_pkg::ST_IDLE;
        end
      end
      sdtq_pkg::ST_PUSH,
      sdtq_pkg::ST_QUERY: begin
        state_d = sdtq_pkg::ST_IDLE;
      end
      default: begin
        state_d = sdtq_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs: chain control and the result of this cycle
  // ---------------------------------------------------------------------------
  always_comb begin
    push_en     = 1'b0;
    pop_en      = 1'b0;
    res_valid   = 1'b0;
    res_kind    = sdtq_pkg::KIND_PUSHED;
    res_entry   = '0;
    res_timeout = '0;
    res_last    = 1'b0;
    count_d     = count_q;
    case (state_q)
      sdtq_pkg::ST_PUSH: begin
        res_valid = 1'b1;
        res_last  = 1'b1;
        if (full) begin
          res_kind = sdtq_pkg::KIND_REJECTED;
        end else begin
          // Insert behind every entry that is not later, keeping FIFO order.
          push_en  = 1'b1;
          count_d  = count_q + CNT_W'(1);
          res_kind = sdtq_pkg::KIND_PUSHED;
        end
      end
      sdtq_pkg::ST_COLLECT: begin
        res_valid = 1'b1;
        if (cell_expired[0]) begin
          // Pop the head and advance the whole chain by one slot.
          pop_en    = 1'b1;
          count_d   = count_q - CNT_W'(1);
          res_kind  = sdtq_pkg::KIND_EXPIRED;
          res_entry = cell_entry[0];
          res_last  = !cell_expired[1];
        end else begin
          res_kind  = sdtq_pkg::KIND_NONE;
          res_last  = 1'b1;
        end
      end
      sdtq_pkg::ST_QUERY: begin
        res_valid = 1'b1;
        res_last  = 1'b1;
        res_kind  = sdtq_pkg::KIND_TIMEOUT;
        if (count_q == '0) begin
          res_timeout = max_delay_q;
        end else if (cell_expired[0]) begin
          res_timeout = '0;
        end else begin
          res_timeout = cell_entry[0].wake_time - now_q;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdtq_pkg::ST_IDLE;
      count_q     <= '0;
      strobe_q    <= 1'b0;
      max_delay_q <= '1;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= res_valid;
      if (cfg_valid_i && cfg_ready_o) begin
        max_delay_q <= cfg_data_i;
      end
    end
  end

  // Hold the command fields for the work cycles that follow the transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q                  <= now_ms_i;
      new_entry_q.wake_time  <= now_ms_i + delay_i;
      new_entry_q.group      <= msg_grp_i;
      new_entry_q.ident      <= msg_id_i;
      new_entry_q.priority_v <= msg_priority_i;
      new_entry_q.handle     <= payload_handle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= res_kind;
    out_entry_q <= res_entry;
    timeout_q   <= res_timeout;
    pend_q      <= count_d;
    last_q      <= res_last;
  end

  assign strobe_o        = strobe_q;
  assign kind_o          = kind_q;
  assign out_group_o     = out_entry_q.group;
  assign out_id_o        = out_entry_q.ident;
  assign out_priority_o  = out_entry_q.priority_v;
  assign out_handle_o    = out_entry_q.handle;
  assign out_wake_time_o = out_entry_q.wake_time;
  assign next_timeout_o  = timeout_q;
  assign pending_count_o = pend_q;
  assign last_o          = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_count_bound, clk_i, (count_q <= CNT_W'(QUEUE_DEPTH)), "occupancy beyond depth")
  `ASSERT_RST(a_pend_ok, clk_i, rst_ni, strobe_o |-> (pending_count_o == count_q), "count off")
  `ASSERT_RST(a_idle_on_last, clk_i, rst_ni, $fell(busy) |-> (strobe_o && last_o), "no last")

endmodule
